// ===== rtl/core/dtwa_pkg.sv =====
// Shared types, constants and width helpers for the device table with ageing.
// Used by dtwa_cell, dtwa_ctrl and the top level device_table_with_ageing.
package dtwa_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 32;
  localparam int POS_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = 5;
  localparam int CMP_W       = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int OUT_CNT_W   = 6;

  // Stream payload widths
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 112;

  localparam logic [31:0] TIMEOUT_RST = 32'd30000;

  typedef enum logic [1:0] {
    CMD_SIGHT = 2'd0,
    CMD_SWEEP = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_UPDATED = 3'd1,
    ST_INSERT  = 3'd2,
    ST_FULL    = 3'd3,
    ST_IGNORED = 3'd4,
    ST_BADIDX  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE    = 2'd0,
    S_ROTATE  = 2'd1,
    S_COMPACT = 2'd2,
    S_RESP    = 2'd3
  } state_e;

  typedef struct packed {
    logic [47:0]        addr;
    logic [1:0]         atype;
    logic signed [7:0]  rssi;
    logic [3:0]         pattern;
    logic [31:0]        seen;
  } entry_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [47:0]        addr;
    logic [1:0]         atype;
    logic signed [7:0]  rssi;
    logic [31:0]        time_ms;
    logic [3:0]         pattern;
    logic [IDX_W-1:0]   read_index;
  } item_t;

  typedef struct packed {
    status_e                status;
    logic [OUT_CNT_W-1:0]   count;
    logic [OUT_CNT_W-1:0]   removed;
    entry_t                 rd;
  } result_t;

  // Per-cell control: load from neighbor, clear valid
  typedef struct packed {
    logic take;
    logic clr;
  } cell_ctl_t;

  // Zero-extend helpers for compares in a common width
  function automatic logic [CMP_W-1:0] cnt_ext(input logic [CNT_W-1:0] v);
    logic [CMP_W+CNT_W-1:0] w;
    w = {{CMP_W{1'b0}}, v};
    return w[CMP_W-1:0];
  endfunction

  function automatic logic [CMP_W-1:0] pos_ext(input logic [POS_W-1:0] v);
    logic [CMP_W+POS_W-1:0] w;
    w = {{CMP_W{1'b0}}, v};
    return w[CMP_W-1:0];
  endfunction

  function automatic logic [CMP_W-1:0] idx_ext(input logic [IDX_W-1:0] v);
    logic [CMP_W+IDX_W-1:0] w;
    w = {{CMP_W{1'b0}}, v};
    return w[CMP_W-1:0];
  endfunction

  // Count reported on the result port, masked to its field width
  function automatic logic [OUT_CNT_W-1:0] cnt_out(input logic [CNT_W-1:0] v);
    logic [OUT_CNT_W+CNT_W-1:0] w;
    w = {{OUT_CNT_W{1'b0}}, v};
    return w[OUT_CNT_W-1:0];
  endfunction

endpackage

// ===== rtl/core/dtwa_cell.sv =====
// One table cell: holds a single entry and its valid flag.
// Loads from its right-hand neighbor on take; depends on dtwa_pkg.
module dtwa_cell
  import dtwa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  entry_t    nbr_i,
  input  logic      nbr_valid_i,
  output entry_t    ent_o,
  output logic      valid_o
);

  entry_t ent_q, ent_d;
  logic   valid_q, valid_d;

  // Take the neighbor's entry, or drop the valid flag on clear
  always_comb begin
    ent_d   = ent_q;
    valid_d = valid_q;
    if (ctl_i.clr) begin
      valid_d = 1'b0;
    end else if (ctl_i.take) begin
      ent_d   = nbr_i;
      valid_d = nbr_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ent_o   = ent_q;
  assign valid_o = valid_q;

endmodule

// ===== rtl/core/dtwa_ctrl.sv =====
// Sequencer for the device table: rotates the cell ring, works on the head
// cell, compacts after a sweep and holds the result beat. Uses dtwa_pkg.
module dtwa_ctrl
  import dtwa_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input beats
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  item_t                  item_i,
  // result beats
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output result_t                res_o,
  // timeout register
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [31:0]            cfg_data_i,
  // cell ring
  input  entry_t                 head_i,
  input  logic                   head_valid_i,
  input  logic [TABLE_DEPTH-1:0] valid_vec_i,
  output entry_t                 tail_o,
  output logic                   tail_valid_o,
  output cell_ctl_t              cell_ctl_o [TABLE_DEPTH]
);

  state_e           state_q, state_d;
  item_t            item_q, item_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] removed_q, removed_d;
  logic             hit_q, hit_d;
  logic [31:0]      timeout_q, timeout_d;
  status_e          status_q, status_d;
  entry_t           rd_q, rd_d;
  logic             out_valid_q, out_valid_d;
  result_t          res_q, res_d;

  logic [TABLE_DEPTH-1:0] low_mask;
  logic [TABLE_DEPTH-1:0] hole;
  logic [31:0]            age;
  logic                   match;
  logic                   packed_ok;

  // Positions below the current count, and holes at or before each cell
  always_comb begin
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      low_mask[k] = pos_ext(POS_W'(k)) < cnt_ext(count_q);
    end
    hole[0] = ~valid_vec_i[0];
    for (int k = 1; k < TABLE_DEPTH; k++) begin
      hole[k] = hole[k-1] | ~valid_vec_i[k];
    end
  end

  assign packed_ok = &(valid_vec_i | ~low_mask);
  assign age       = item_q.time_ms - head_i.seen;
  assign match     = head_valid_i && (head_i.addr == item_q.addr) && !hit_q;

  // Next state and ring control
  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    pos_d        = pos_q;
    count_d      = count_q;
    removed_d    = removed_q;
    hit_d        = hit_q;
    timeout_d    = timeout_q;
    status_d     = status_q;
    rd_d         = rd_q;
    out_valid_d  = out_valid_q;
    res_d        = res_q;
    tail_o       = head_i;
    tail_valid_o = head_valid_i;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      cell_ctl_o[k] = '0;
    end

    if (cfg_valid_i) begin
      timeout_d = cfg_data_i;
    end

    // drop a result beat once taken
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d    = item_i;
          pos_d     = '0;
          hit_d     = 1'b0;
          removed_d = '0;
          rd_d      = '0;
          status_d  = ST_DONE;
          case (item_i.cmd)
            CMD_SIGHT: begin
              if (item_i.pattern == 4'd0) begin
                status_d = ST_IGNORED;
                state_d  = S_RESP;
              end else begin
                state_d = S_ROTATE;
              end
            end
            CMD_SWEEP: begin
              state_d = S_ROTATE;
            end
            CMD_CLEAR: begin
              for (int k = 0; k < TABLE_DEPTH; k++) begin
                cell_ctl_o[k].clr = 1'b1;
              end
              removed_d = count_q;
              count_d   = '0;
              state_d   = S_RESP;
            end
            CMD_READ: begin
              if (idx_ext(item_i.read_index) >= cnt_ext(count_q)) begin
                status_d = ST_BADIDX;
                state_d  = S_RESP;
              end else begin
                state_d = S_ROTATE;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_ROTATE: begin
        // advance every cell by one, feeding the worked head back to the tail
        for (int k = 0; k < TABLE_DEPTH; k++) begin
          cell_ctl_o[k].take = 1'b1;
        end
        pos_d = pos_q + POS_W'(1);
        case (item_q.cmd)
          CMD_SIGHT: begin
            if (match) begin
              tail_o.rssi = item_q.rssi;
              tail_o.seen = item_q.time_ms;
              hit_d       = 1'b1;
              status_d    = ST_UPDATED;
            end else if (!hit_q && (pos_ext(pos_q) == cnt_ext(count_q)) &&
                         (count_q < CNT_W'(TABLE_DEPTH))) begin
              // append once, at the first free position
              tail_o.addr      = item_q.addr;
              tail_o.atype     = item_q.atype;
              tail_o.rssi      = item_q.rssi;
              tail_o.pattern   = item_q.pattern;
              tail_o.seen      = item_q.time_ms;
              tail_valid_o     = 1'b1;
              count_d          = count_q + CNT_W'(1);
              hit_d            = 1'b1;
              status_d         = ST_INSERT;
            end
          end
          CMD_SWEEP: begin
            if (head_valid_i && (age > timeout_q)) begin
              tail_valid_o = 1'b0;
              removed_d    = removed_q + CNT_W'(1);
              count_d      = count_q - CNT_W'(1);
            end
          end
          CMD_READ: begin
            if (pos_ext(pos_q) == idx_ext(item_q.read_index)) begin
              rd_d = head_i;
            end
          end
          default: begin
          end
        endcase
        if (pos_q == POS_W'(TABLE_DEPTH - 1)) begin
          if ((item_q.cmd == CMD_SIGHT) && (status_d == ST_DONE)) begin
            status_d = ST_FULL;
          end
          state_d = (item_q.cmd == CMD_SWEEP) ? S_COMPACT : S_RESP;
        end
      end

      S_COMPACT: begin
        // close the first hole each cycle until the survivors sit in front
        if (packed_ok) begin
          state_d = S_RESP;
        end else begin
          for (int k = 0; k < TABLE_DEPTH; k++) begin
            cell_ctl_o[k].take = hole[k];
          end
          tail_valid_o = 1'b0;
        end
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d     = 1'b1;
          res_d.status    = status_q;
          res_d.count     = cnt_out(count_q);
          res_d.removed   = cnt_out(removed_q);
          res_d.rd        = rd_q;
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      count_q     <= '0;
      removed_q   <= '0;
      hit_q       <= 1'b0;
      timeout_q   <= TIMEOUT_RST;
      status_q    <= ST_DONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      count_q     <= count_d;
      removed_q   <= removed_d;
      hit_q       <= hit_d;
      timeout_q   <= timeout_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    rd_q   <= rd_d;
    res_q  <= res_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign cfg_ready_o = 1'b1;

endmodule

// ===== rtl/core/device_table_with_ageing.sv =====
// Device table with ageing: a ring of TABLE_DEPTH cells plus a sequencer (dtwa_pkg).
// Sighting and good read: the result beat follows one full rotation of the ring.
// Sweep: one full rotation, then compaction closing the holes of removed entries.
// Clear, ignored sighting and read beyond the count: no rotation, straight to the result.
// One item at a time; the next beat is taken once the result enters the output register.
// Reset: count 0, timeout 30000 ms, no clearing pass; entry payload not reset.
module device_table_with_ageing
  import dtwa_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // addr[47:0], atype[49:48], rssi[57:50], time_ms[89:58],
  // pattern[93:90], read_index[98:94], zero pad[103:99]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // cmd[1:0]
  input  logic [1:0]             s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // count[5:0], removed[11:6], rd_addr[59:12], rd_atype[61:60],
  // rd_rssi[69:62], rd_pattern[73:70], rd_last_seen[105:74], zero pad[111:106]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // status[2:0]
  output logic [2:0]             m_axis_tuser_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [31:0]            cfg_data_i
);

  item_t                  item;
  result_t                res;
  entry_t                 ent [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_vec;
  entry_t                 tail;
  logic                   tail_valid;
  cell_ctl_t              cell_ctl [TABLE_DEPTH];

  // Unpack the input beat
  assign item.cmd        = cmd_e'(s_axis_tuser_i);
  assign item.addr       = s_axis_tdata_i[47:0];
  assign item.atype      = s_axis_tdata_i[49:48];
  assign item.rssi       = s_axis_tdata_i[57:50];
  assign item.time_ms    = s_axis_tdata_i[89:58];
  assign item.pattern    = s_axis_tdata_i[93:90];
  assign item.read_index = s_axis_tdata_i[98:94];

  dtwa_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .item_i       (item),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .res_o        (res),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .head_i       (ent[0]),
    .head_valid_i (valid_vec[0]),
    .valid_vec_i  (valid_vec),
    .tail_o       (tail),
    .tail_valid_o (tail_valid),
    .cell_ctl_o   (cell_ctl)
  );

  // Chain of cells: each loads from its right neighbor, the last from the tail
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    entry_t nbr;
    logic   nbr_valid;
    if (k == TABLE_DEPTH - 1) begin : g_last
      assign nbr       = tail;
      assign nbr_valid = tail_valid;
    end else begin : g_mid
      assign nbr       = ent[k+1];
      assign nbr_valid = valid_vec[k+1];
    end
    dtwa_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (cell_ctl[k]),
      .nbr_i       (nbr),
      .nbr_valid_i (nbr_valid),
      .ent_o       (ent[k]),
      .valid_o     (valid_vec[k])
    );
  end

  // Pack the result beat
  assign m_axis_tdata_o = {6'd0, res.rd.seen, res.rd.pattern, res.rd.rssi,
                           res.rd.atype, res.rd.addr, res.removed, res.count};
  assign m_axis_tuser_o = res.status;

endmodule
